### design/ppd_pkg.sv
// Shared types and constants for the planar PackBits decoder.
// Used by ppd_run_clip, ppd_out_skid and planar_packbits_decoder_unit.
`timescale 1ns / 1ps

package ppd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_PLANE_COUNT = 2'd1;
  localparam logic [1:0] CFG_RAW_MODE    = 2'd2;

  localparam int CFG_DATA_W  = 25;
  localparam int START_PIX_W = 24;

  // Register values after reset.
  localparam logic [24:0] PIXEL_COUNT_RST = 25'd1;
  localparam logic [4:0]  PLANE_COUNT_RST = 5'd3;

  // PackBits header codes.
  localparam logic [7:0] HDR_NOOP = 8'd128;

  // One run result as it leaves the block.
  typedef struct packed {
    logic [1:0]             channel;
    logic [START_PIX_W-1:0] start_pixel;
    logic [7:0]             value;
    logic [7:0]             repeat_res;
    logic                   plane_end;
    logic                   image_end;
    logic                   overrun;
  } result_t;

endpackage

### design/ppd_run_clip.sv
// Clips one run against the current plane and works out the next position and plane.
// Depends on ppd_pkg for result_t.
`timescale 1ns / 1ps

module ppd_run_clip #(
  parameter int DECODED_PLANES = 4,
  parameter int POSITION_BITS  = 24
) (
  input  logic [24:0]                                   pixel_count,
  input  logic [4:0]                                    plane_count,
  input  logic [((POSITION_BITS < 25) ? POSITION_BITS : 25)-1:0] pixel_pos,
  input  logic [1:0]                                    plane,
  input  logic [7:0]                                    value,
  input  logic [7:0]                                    run_len,
  input  logic                                          more_pending,
  output ppd_pkg::result_t                              res,
  output logic [((POSITION_BITS < 25) ? POSITION_BITS : 25)-1:0] pixel_pos_nxt,
  output logic [1:0]                                    plane_nxt
);

  localparam int PW = (POSITION_BITS < 25) ? POSITION_BITS : 25;
  localparam int EW = (POSITION_BITS < 25) ? POSITION_BITS + 1 : 25;
  localparam logic [25:0] CAP = (POSITION_BITS < 25) ? (26'd1 << POSITION_BITS)
                                                     : {1'b1, 25'd0};
  localparam logic [2:0] MAX_PLANES = 3'(DECODED_PLANES);

  logic [25:0]   pc_ext;
  logic [25:0]   eff_ext;
  logic [EW-1:0] eff_pix;
  logic [EW-1:0] pos_ext;
  logic [EW-1:0] rem;
  logic [7:0]    take;
  logic          pend;
  logic [2:0]    eff_planes;
  logic          iend;
  logic [31:0]   pos_wide;

  assign pc_ext  = {1'b0, pixel_count};
  assign eff_ext = (pixel_count == '0) ? 26'd1 : ((pc_ext > CAP) ? CAP : pc_ext);
  assign eff_pix = eff_ext[EW-1:0];
  assign pos_ext = EW'(pixel_pos);

  // A position already past a lowered pixel count leaves room for one pixel only.
  assign rem  = (pos_ext < eff_pix) ? (eff_pix - pos_ext) : EW'(1);
  assign take = (EW'(run_len) < rem) ? run_len : rem[7:0];
  assign pend = (EW'(take) == rem);

  assign eff_planes = (plane_count == '0) ? 3'd1
                    : ((plane_count > 5'(MAX_PLANES)) ? MAX_PLANES : plane_count[2:0]);
  assign iend = pend && ((3'(plane) + 3'd1) >= eff_planes);

  assign pos_wide = 32'(pixel_pos);

  always_comb begin
    res.channel     = plane;
    res.start_pixel = pos_wide[ppd_pkg::START_PIX_W-1:0];
    res.value       = value;
    res.repeat_res  = take;
    res.plane_end   = pend;
    res.image_end   = iend;
    res.overrun     = (run_len > take) || (pend && more_pending);
  end

  assign pixel_pos_nxt = pend ? '0 : PW'(pos_ext + EW'(take));
  assign plane_nxt     = (pend && !iend) ? (plane + 2'd1) : plane;

endmodule

### design/ppd_out_skid.sv
// Result register with one skid entry, so input beats keep flowing while a result waits.
// Depends on ppd_pkg for result_t.
`timescale 1ns / 1ps

module ppd_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ppd_pkg::result_t push_res,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output ppd_pkg::result_t out_res
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  ppd_pkg::result_t out_res_r, out_res_nxt;
  ppd_pkg::result_t skid_res_r, skid_res_nxt;
  logic             drain;

  assign drain     = out_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (drain) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || drain) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (drain) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

### design/planar_packbits_decoder_unit.sv
// Channel   Direction  Handshake              Beat carries
// in_       input      in_valid / in_ready    one byte of the image data stream
// out_      output     out_valid / out_ready  one run: channel, start, value, length, flags
// cfg_      input      cfg_we                 register index and write data
//
// One byte is taken per cycle while in_ready is high; the header parse and run
// clipping sit between the input and a result register, so each result is registered.
// A result register plus one skid entry decouple the sides: in_ready drops only
// when both are full. Reset is synchronous, clears run state and reloads config registers.
// Depends on ppd_pkg, ppd_run_clip and ppd_out_skid.
`timescale 1ns / 1ps

module planar_packbits_decoder_unit #(
  parameter int DECODED_PLANES = 4,
  parameter int POSITION_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_channel,
  output logic [ppd_pkg::START_PIX_W-1:0]   out_start_pixel,
  output logic [7:0]                        out_value,
  output logic [7:0]                        out_repeat_res,
  output logic                              out_plane_end,
  output logic                              out_image_end,
  output logic                              out_overrun,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PW = (POSITION_BITS < 25) ? POSITION_BITS : 25;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;
  localparam logic [1:0] PH_SKIP    = 2'd3;

  logic [24:0]   pixel_count_r;
  logic [4:0]    plane_count_r;
  logic          raw_mode_r;

  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    literal_left_r, literal_left_nxt;
  logic [7:0]    run_length_r, run_length_nxt;
  logic [PW-1:0] pixel_pos_r, pixel_pos_nxt;
  logic [1:0]    plane_r, plane_nxt;
  logic          finished_r, finished_nxt;

  logic          accept;
  logic          push;
  logic [7:0]    run_len;
  logic          more_pending;
  logic [7:0]    lit_eff;
  logic [7:0]    lit_dec;
  logic [PW-1:0] clip_pos_nxt;
  logic [1:0]    clip_plane_nxt;
  logic          space;

  ppd_pkg::result_t clip_res;
  ppd_pkg::result_t out_res;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  // A literal counter of zero is read as one so a run always moves on.
  assign lit_eff = (literal_left_r == '0) ? 8'd1 : literal_left_r;
  assign lit_dec = lit_eff - 8'd1;

  always_comb begin
    push         = 1'b0;
    run_len      = 8'd1;
    more_pending = 1'b0;
    if (accept && !finished_r) begin
      if (raw_mode_r) begin
        push = 1'b1;
      end else begin
        case (phase_r)
          PH_LITERAL: begin
            push         = 1'b1;
            more_pending = (lit_eff > 8'd1);
          end
          PH_REPEAT: begin
            push    = 1'b1;
            run_len = (run_length_r == '0) ? 8'd1 : run_length_r;
          end
          default: push = 1'b0;
        endcase
      end
    end
  end

  ppd_run_clip #(
    .DECODED_PLANES (DECODED_PLANES),
    .POSITION_BITS  (POSITION_BITS)
  ) u_run_clip (
    .pixel_count   (pixel_count_r),
    .plane_count   (plane_count_r),
    .pixel_pos     (pixel_pos_r),
    .plane         (plane_r),
    .value         (in_data_byte),
    .run_len       (run_len),
    .more_pending  (more_pending),
    .res           (clip_res),
    .pixel_pos_nxt (clip_pos_nxt),
    .plane_nxt     (clip_plane_nxt)
  );

  always_comb begin
    phase_nxt        = phase_r;
    literal_left_nxt = literal_left_r;
    run_length_nxt   = run_length_r;
    pixel_pos_nxt    = pixel_pos_r;
    plane_nxt        = plane_r;
    finished_nxt     = finished_r;
    if (push) begin
      pixel_pos_nxt = clip_pos_nxt;
      plane_nxt     = clip_plane_nxt;
      finished_nxt  = clip_res.image_end;
    end
    if (accept && !finished_r) begin
      if (raw_mode_r) begin
        phase_nxt        = PH_HEADER;
        literal_left_nxt = '0;
        run_length_nxt   = '0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (in_data_byte < ppd_pkg::HDR_NOOP) begin
              literal_left_nxt = in_data_byte + 8'd1;
              phase_nxt        = PH_LITERAL;
            end else if (in_data_byte > ppd_pkg::HDR_NOOP) begin
              run_length_nxt = (~in_data_byte) + 8'd2;
              phase_nxt      = PH_REPEAT;
            end
          end
          PH_LITERAL: begin
            literal_left_nxt = lit_dec;
            if (lit_dec == '0) begin
              phase_nxt = PH_HEADER;
            end else if (clip_res.plane_end) begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_REPEAT: begin
            run_length_nxt = '0;
            phase_nxt      = PH_HEADER;
          end
          default: begin
            // Rest of a literal run that spilled past the plane end.
            if (literal_left_r != '0) begin
              literal_left_nxt = literal_left_r - 8'd1;
            end
            if (literal_left_r <= 8'd1) begin
              phase_nxt = PH_HEADER;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      literal_left_r <= '0;
      run_length_r   <= '0;
      pixel_pos_r    <= '0;
      plane_r        <= '0;
      finished_r     <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      literal_left_r <= literal_left_nxt;
      run_length_r   <= run_length_nxt;
      pixel_pos_r    <= pixel_pos_nxt;
      plane_r        <= plane_nxt;
      finished_r     <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= ppd_pkg::PIXEL_COUNT_RST;
      plane_count_r <= ppd_pkg::PLANE_COUNT_RST;
      raw_mode_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppd_pkg::CFG_PIXEL_COUNT: pixel_count_r <= cfg_wdata[24:0];
        ppd_pkg::CFG_PLANE_COUNT: plane_count_r <= cfg_wdata[4:0];
        ppd_pkg::CFG_RAW_MODE:    raw_mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ppd_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (clip_res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_channel     = out_res.channel;
  assign out_start_pixel = out_res.start_pixel;
  assign out_value       = out_res.value;
  assign out_repeat_res  = out_res.repeat_res;
  assign out_plane_end   = out_res.plane_end;
  assign out_image_end   = out_res.image_end;
  assign out_overrun     = out_res.overrun;

  // Once the image is complete no further run may be produced.
  a_no_run_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !push)
    else $error("run produced after image end");

  // The skip phase is only ever held with bytes of the literal run still to drop.
  a_skip_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (literal_left_r != '0))
    else $error("skip phase with empty literal counter");

  // A run that closes a plane restarts the position at pixel zero.
  a_plane_end_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (push && clip_res.plane_end) |=> (pixel_pos_r == '0))
    else $error("pixel position not cleared at plane end");

  // Output stays valid while a result is parked in the skid entry.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("skid entry full with result register empty");

endmodule
